// ===== rtl/fpsq_pkg.sv =====
// ----------------------------------------------------------------------------
// fpsq_pkg
// Shared constants and types of the binary64 power-by-squaring unit.
// ----------------------------------------------------------------------------
package fpsq_pkg;

	localparam int FPSQ_EXP_BITS = 31;
	localparam int F64_W         = 64;
	localparam int EXPN_W        = 31;

	localparam logic [F64_W-1:0] F64_ONE  = 64'h3FF0_0000_0000_0000;
	localparam logic [F64_W-1:0] F64_QNAN = 64'h7FF8_0000_0000_0000;

	typedef enum logic [1:0] {
		OPA_BASE = 2'd0,
		OPA_R    = 2'd1,
		OPA_T    = 2'd2
	} opa_sel_t;

	typedef struct packed {
		logic     load;
		logic     start;
		opa_sel_t a_sel;
		logic     dst_t;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
	} dp_sts_t;

endpackage

// ===== rtl/fpsq_in_if.sv =====
// ----------------------------------------------------------------------------
// fpsq_in_if
// Operand channel: base bit pattern and exponent.
// ----------------------------------------------------------------------------
interface fpsq_in_if import fpsq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [F64_W-1:0]  base_bits;
	logic [EXPN_W-1:0] exponent;

	modport source (output valid, output base_bits, output exponent, input ready);
	modport sink   (input valid, input base_bits, input exponent, output ready);
endinterface

// ===== rtl/fpsq_out_if.sv =====
// ----------------------------------------------------------------------------
// fpsq_out_if
// Result channel: binary64 bit pattern.
// ----------------------------------------------------------------------------
interface fpsq_out_if import fpsq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [F64_W-1:0] result_bits;

	modport source (output valid, output result_bits, input ready);
	modport sink   (input valid, input result_bits, output ready);
endinterface

// ===== rtl/fpsq_fmul.sv =====
// ----------------------------------------------------------------------------
// fpsq_fmul
// Multi-cycle binary64 multiplier, round to nearest even, IEEE specials.
// ----------------------------------------------------------------------------
module fpsq_fmul import fpsq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [F64_W-1:0] a,
	input  logic [F64_W-1:0] b,
	output logic             done,
	output logic [F64_W-1:0] y
);

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_MUL  = 4'b0010,
		M_NORM = 4'b0100,
		M_RND  = 4'b1000
	} mstate_t;

	mstate_t            state_q;
	logic               done_q;
	logic [F64_W-1:0]   y_q;
	logic [52:0]        ma_q, mb_q;
	logic               s_q;
	logic signed [12:0] x_q;
	logic [105:0]       acc_q;
	logic [2:0]         k_q;
	logic [53:0]        pp_q;
	logic [1:0]         pk_q;
	logic               ppv_q;

	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
	logic [26:0] opa, opb;
	logic [105:0] pp_sh;
	logic [52:0] mant;
	logic        up;
	logic [53:0] m54;
	logic signed [12:0] xf;
	logic [10:0] efield;

	always_comb begin
		a_nan  = (a[62:52] == 11'h7FF) && (a[51:0] != '0);
		b_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
		a_inf  = (a[62:52] == 11'h7FF) && (a[51:0] == '0);
		b_inf  = (b[62:52] == 11'h7FF) && (b[51:0] == '0);
		a_zero = (a[62:0] == '0);
		b_zero = (b[62:0] == '0);
		sgn    = a[63] ^ b[63];

		opa = k_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
		opb = k_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];

		unique case (pk_q)
			2'd0:    pp_sh = 106'(pp_q);
			2'd3:    pp_sh = 106'(pp_q) << 54;
			default: pp_sh = 106'(pp_q) << 27;
		endcase

		mant = acc_q[105:53];
		up   = acc_q[52] & ((|acc_q[51:0]) | mant[0]);
		m54  = {1'b0, mant} + 54'(up);
		if (m54[53]) begin
			xf     = x_q + 13'sd1;
			efield = xf[10:0];
		end else begin
			xf     = x_q;
			efield = m54[52] ? x_q[10:0] : 11'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
			ppv_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
							y_q    <= F64_QNAN;
							done_q <= 1'b1;
						end else if (a_inf || b_inf) begin
							y_q    <= {sgn, 11'h7FF, 52'd0};
							done_q <= 1'b1;
						end else if (a_zero || b_zero) begin
							y_q    <= {sgn, 63'd0};
							done_q <= 1'b1;
						end else begin
							ma_q    <= {a[62:52] != '0, a[51:0]};
							mb_q    <= {b[62:52] != '0, b[51:0]};
							s_q     <= sgn;
							x_q     <= $signed({2'b0, (a[62:52] == '0) ? 11'd1 : a[62:52]})
							         + $signed({2'b0, (b[62:52] == '0) ? 11'd1 : b[62:52]})
							         - 13'sd1022;
							acc_q   <= '0;
							k_q     <= '0;
							ppv_q   <= 1'b0;
							state_q <= M_MUL;
						end
					end
				end
				M_MUL: begin
					if (k_q < 3'd4) begin
						pp_q  <= opa * opb;
						pk_q  <= k_q[1:0];
						ppv_q <= 1'b1;
					end else begin
						ppv_q <= 1'b0;
					end
					if (ppv_q) acc_q <= acc_q + pp_sh;
					k_q <= k_q + 3'd1;
					if (k_q == 3'd4) state_q <= M_NORM;
				end
				M_NORM: begin
					if (!acc_q[105] && x_q > 13'sd1) begin
						if (acc_q[105:98] == '0 && x_q > 13'sd8) begin
							acc_q <= acc_q << 8;
							x_q   <= x_q - 13'sd8;
						end else begin
							acc_q <= acc_q << 1;
							x_q   <= x_q - 13'sd1;
						end
					end else if (x_q < 13'sd1) begin
						if (x_q < -13'sd60) begin
							acc_q <= {105'd0, |acc_q};
							x_q   <= 13'sd1;
						end else if (x_q < -13'sd6) begin
							acc_q <= {8'd0, acc_q[105:9], |acc_q[8:0]};
							x_q   <= x_q + 13'sd8;
						end else begin
							acc_q <= {1'b0, acc_q[105:2], |acc_q[1:0]};
							x_q   <= x_q + 13'sd1;
						end
					end else begin
						state_q <= M_RND;
					end
				end
				M_RND: begin
					if (xf >= 13'sd2047) y_q <= {s_q, 11'h7FF, 52'd0};
					else                 y_q <= {s_q, efield, m54[51:0]};
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign y    = y_q;

endmodule

// ===== rtl/fpsq_dp.sv =====
// ----------------------------------------------------------------------------
// fpsq_dp
// Datapath: base, accumulator and temporary registers around the multiplier.
// ----------------------------------------------------------------------------
module fpsq_dp import fpsq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	input  logic [F64_W-1:0] base_bits,
	output logic [F64_W-1:0] result_bits
);

	logic [F64_W-1:0] base_q, r_q, t_q, res_q;
	logic [F64_W-1:0] opa, y;
	logic             done;

	always_comb begin
		unique case (cmd.a_sel)
			OPA_BASE: opa = base_q;
			OPA_T:    opa = t_q;
			default:  opa = r_q;
		endcase
	end

	fpsq_fmul u_fmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.a      (opa),
		.b      (r_q),
		.done   (done),
		.y      (y)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= base_bits;
			r_q    <= F64_ONE;
		end else if (done) begin
			if (cmd.dst_t) t_q <= y;
			else           r_q <= y;
		end
		if (cmd.out_load) begin
			if (r_q[62:52] == 11'h7FF && r_q[51:0] != '0) res_q <= F64_QNAN;
			else                                          res_q <= r_q;
		end
	end

	assign sts.mul_done = done;
	assign result_bits  = res_q;

endmodule

// ===== rtl/fpsq_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpsq_ctrl
// Controller: scans exponent bits MSB first and sequences the multiplies.
// ----------------------------------------------------------------------------
module fpsq_ctrl import fpsq_pkg::*; #(
	parameter int EXP_BITS = FPSQ_EXP_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [EXPN_W-1:0] exponent,
	output logic              out_valid,
	input  logic              out_ready,
	output dp_cmd_t           cmd,
	input  dp_sts_t           sts
);

	localparam int CW = $clog2(EXP_BITS + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_WAIT  = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t              state_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [CW-1:0]       cnt_q;
	logic                ph_q;
	logic                ov_q;
	logic [63:0]         e64;
	logic                bit_now;

	assign e64     = 64'(exponent);
	assign bit_now = exp_q[EXP_BITS-1];

	always_comb begin
		in_ready     = (state_q == S_IDLE);
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.start    = (state_q == S_ISSUE);
		cmd.a_sel    = bit_now ? (ph_q ? OPA_T : OPA_BASE) : OPA_R;
		cmd.dst_t    = bit_now && !ph_q;
		cmd.out_load = (state_q == S_FIN) && (!ov_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
			ph_q    <= 1'b0;
		end else begin
			if (cmd.out_load)  ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						exp_q   <= e64[EXP_BITS-1:0];
						cnt_q   <= CW'(EXP_BITS - 1);
						ph_q    <= 1'b0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (sts.mul_done) begin
						if (bit_now && !ph_q) begin
							ph_q <= 1'b1;
						end else begin
							ph_q  <= 1'b0;
							exp_q <= exp_q << 1;
							if (cnt_q != '0) cnt_q <= cnt_q - CW'(1);
						end
						if (!(bit_now && !ph_q) && cnt_q == '0) state_q <= S_FIN;
						else                                     state_q <= S_ISSUE;
					end
				end
				S_FIN: begin
					if (!ov_q || out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;

endmodule

// ===== rtl/float_power_by_squaring_unit.sv =====
// ----------------------------------------------------------------------------
// float_power_by_squaring_unit
// binary64 base raised to an unsigned integer power by binary exponentiation.
// ----------------------------------------------------------------------------
//  channel   dir  payload                         transaction
//  operand   in   base_bits[63:0], exponent[30:0]  valid & ready
//  result    out  result_bits[63:0]               valid & ready
//
//  One multiply runs issue, 4 partial products on one 27x27 multiplier,
//  normalize, round and done; subnormal operands or results add normalize
//  steps, and a zero, infinite or NaN operand goes straight to done.
//  An item takes EXP_BITS squarings plus one extra multiply per set bit;
//  one item is in work at a time. arst_n clears all control state; the
//  output register holds a result while result.ready is low and a new
//  operand is accepted meanwhile.
// ----------------------------------------------------------------------------
module float_power_by_squaring_unit import fpsq_pkg::*; #(
	parameter int EXP_BITS = FPSQ_EXP_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	fpsq_in_if.sink    operand,
	fpsq_out_if.source result
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	fpsq_ctrl #(.EXP_BITS(EXP_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operand.valid),
		.in_ready  (operand.ready),
		.exponent  (operand.exponent),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	fpsq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.base_bits   (operand.base_bits),
		.result_bits (result.result_bits)
	);

endmodule

// ===== dv/fpsq_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// fpsq_tb_pkg
// Scoreboard for the binary64 power unit: predicts base**exponent by binary
// exponentiation on host doubles and checks results in order.
// ----------------------------------------------------------------------------
package fpsq_tb_pkg;
	import fpsq_pkg::*;

	class fpsq_scoreboard;
		logic [F64_W-1:0] pending_pow[$];
		int               errors = 0;

		function logic [F64_W-1:0] power_of(logic [F64_W-1:0] base, logic [EXPN_W-1:0] expn);
			real              b;
			real              r;
			logic [F64_W-1:0] bits;
			b = $bitstoreal(base);
			r = 1.0;
			for (int i = FPSQ_EXP_BITS - 1; i >= 0; i--) begin
				if (expn[i]) begin
					r = (b * r) * r;
				end else begin
					r = r * r;
				end
			end
			bits = $realtobits(r);
			if (bits[62:52] == 11'h7FF && bits[51:0] != 0) begin
				bits = F64_QNAN;
			end
			return bits;
		endfunction

		function void note_operand(logic [F64_W-1:0] base, logic [EXPN_W-1:0] expn);
			pending_pow.push_back(power_of(base, expn));
		endfunction

		function void check_result(logic [F64_W-1:0] got);
			logic [F64_W-1:0] want;
			if (pending_pow.size() == 0) begin
				$error("result_bits: unexpected transaction, actual %h", got);
				errors++;
			end else begin
				want = pending_pow.pop_front();
				if (got !== want) begin
					$error("result_bits: expected %h, actual %h", want, got);
					errors++;
				end
			end
		endfunction
	endclass
endpackage

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives operands with random gaps and result back-pressure, including one
// long receiver hold-off and one drain pause; checks every transaction.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fpsq_pkg::*;
	import fpsq_tb_pkg::*;

	localparam int N_RANDOM = 1330;

	logic clk = 1'b0;
	logic arst_n;
	int   n_results = 0;
	bit   held = 0;

	fpsq_in_if  opnd();
	fpsq_out_if res();

	float_power_by_squaring_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (opnd.sink),
		.result  (res.source)
	);

	fpsq_scoreboard sb = new();

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (opnd.valid && opnd.ready) begin
			sb.note_operand(opnd.base_bits, opnd.exponent);
		end
		if (res.valid && res.ready) begin
			sb.check_result(res.result_bits);
			n_results++;
		end
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 4) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
		return $urandom_range(1, 4);
	endfunction

	task automatic send(logic [F64_W-1:0] base, logic [EXPN_W-1:0] expn, bit idle_after);
		int gap;
		opnd.valid     <= 1'b1;
		opnd.base_bits <= base;
		opnd.exponent  <= expn;
		@(posedge clk);
		while (!opnd.ready) @(posedge clk);
		gap = idle_after ? pick_gap() : 0;
		if (gap > 0) begin
			opnd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result side back-pressure, with a single long hold-off
	initial begin
		int stall;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && n_results >= 100) begin
				held = 1;
				res.ready <= 1'b0;
				repeat (4000) @(posedge clk);
			end
			stall = pick_gap();
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	initial begin
		logic [F64_W-1:0] specials[12];
		logic [EXPN_W-1:0] dexp[6];
		logic [F64_W-1:0] b;
		logic [EXPN_W-1:0] e;
		int               k;
		specials = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
			64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'h0000_0000_0000_0001,
			64'h7FEF_FFFF_FFFF_FFFF, F64_ONE, 64'hBFF0_0000_0000_0000,
			64'h4000_0000_0000_0000, 64'h3FE0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF};
		dexp = '{31'd0, 31'd1, 31'd2, 31'h7FFF_FFFF, 31'd1024, 31'd1075};
		arst_n          = 1'b0;
		opnd.valid     <= 1'b0;
		opnd.base_bits <= '0;
		opnd.exponent  <= '0;
		repeat (9) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		for (int i = 0; i < 20; i++) begin
			send(specials[i % 12], dexp[i % 6], 1'b1);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 600) begin
				opnd.valid <= 1'b0;
				@(posedge clk);
				while (sb.pending_pow.size() != 0) @(posedge clk);
			end
			k = $urandom_range(0, 99);
			if (k < 60) begin
				b = {$urandom, $urandom};
				b[62:52] = 11'(1023 + $urandom_range(0, 20) - 10);
				e = EXPN_W'($urandom_range(0, 40));
			end else if (k < 75) begin
				b = {$urandom, $urandom};
				e = EXPN_W'($urandom_range(0, 8));
			end else if (k < 90) begin
				b = {$urandom, $urandom};
				e = EXPN_W'($urandom);
			end else begin
				b = specials[$urandom_range(0, 11)];
				b[63] = 1'($urandom_range(0, 1));
				e = ($urandom_range(0, 1)) ? EXPN_W'($urandom) : EXPN_W'($urandom_range(0, 3));
			end
			send(b, e, i < 900 || i > 1000);
		end
		opnd.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_pow.size() != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
		if (sb.errors == 0 && sb.pending_pow.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#250ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/fpsq_pkg.sv
rtl/fpsq_in_if.sv
rtl/fpsq_out_if.sv
rtl/fpsq_fmul.sv
rtl/fpsq_dp.sv
rtl/fpsq_ctrl.sv
rtl/float_power_by_squaring_unit.sv
dv/fpsq_tb_pkg.sv
dv/tb_top.sv
